>>> hdl/pts_pkg.sv
// Shared constants, register indexes and types of the packed triangle unpacker.
`default_nettype none

package pts_pkg;

  localparam int MAX_ORDER     = 64;
  localparam int VALUE_BITS    = 32;
  localparam int POS_BITS      = 6;
  localparam int ORDER_BITS    = 7;
  localparam int PIDX_BITS     = 12;
  localparam int SCALE_BITS    = 17;
  localparam int SCALE_FRAC    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER         = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFDIAG_SCALE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_SPARSE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_SPARSE = 2'd3;

  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 7'd1;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 17'd46341;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_CALC = 5'b00100,
    S_OUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef enum logic {
    OP_SCALE = 1'b0,
    OP_HALVE = 1'b1
  } op_e;

endpackage

`default_nettype wire

>>> hdl/pts_scale.sv
// Shared arithmetic unit: scales by the Q1.16 factor or halves, then saturates.
`default_nettype none

module pts_scale
  import pts_pkg::*;
(
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  input  wire logic        [SCALE_BITS-1:0] scale_i,
  input  wire op_e                          op_i,
  output logic signed      [VALUE_BITS-1:0] result_o
);

  localparam int PROD_BITS = VALUE_BITS + SCALE_BITS;
  localparam int Q_BITS    = VALUE_BITS + 2;

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [PROD_BITS-1:0]  prod;
  logic [Q_BITS-1:0]     q;
  logic [Q_BITS-1:0]     lim;
  logic [Q_BITS-1:0]     sat;

  assign neg  = value_i[VALUE_BITS-1];
  assign mag  = neg ? (~value_i + 1'b1) : value_i;
  assign prod = PROD_BITS'(mag) * PROD_BITS'(scale_i);
  assign lim  = Q_BITS'(1) << (VALUE_BITS - 1);

  always_comb begin
    case (op_i)
      OP_SCALE: begin
        // Negative values round toward minus infinity, so the magnitude rounds up.
        q = Q_BITS'(prod[PROD_BITS-1:SCALE_FRAC])
            + Q_BITS'(neg && (prod[SCALE_FRAC-1:0] != '0));
      end
      OP_HALVE: begin
        q = Q_BITS'(mag >> 1) + Q_BITS'(neg & mag[0]);
      end
      default: begin
        q = '0;
      end
    endcase
    if (neg) begin
      sat = (q > lim) ? lim : q;
      result_o = VALUE_BITS'(~sat + 1'b1);
    end else begin
      sat = (q > lim - 1'b1) ? (lim - 1'b1) : q;
      result_o = VALUE_BITS'(sat);
    end
  end

endmodule

`default_nettype wire

>>> hdl/packed_triangle_to_symmetric.sv
// Top level of the packed upper triangle to symmetric matrix entry unpacker.
// One item is taken at a time; in_stall_o is high from acceptance until its
// last result has been taken. A dense-input item is accepted in S_IDLE, goes
// through the shared scale unit in S_CALC and waits in S_OUT for each result
// to be taken (two results for an off-diagonal element with dense output). A
// sparse-input item whose index does not descend first goes through the column
// walk in S_WALK, which steps one column per cycle through a single add and
// compare. A zero dropped without a marker passes S_CALC and S_DONE and gives
// no result. Configuration writes are taken in any cycle and are meant for
// idle periods only.
`default_nettype none

module packed_triangle_to_symmetric
  import pts_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  input  wire logic [PIDX_BITS-1:0]         packed_index_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [POS_BITS-1:0]               row_o,
  output logic [POS_BITS-1:0]               col_o,
  output logic signed [VALUE_BITS-1:0]      entry_o,
  output logic                              entry_valid_o,
  output logic                              index_error_o,
  output logic                              last_out_o
);

  state_e state_q, state_d;

  logic [ORDER_BITS-1:0] order_q;
  logic [SCALE_BITS-1:0] scale_q;
  logic                  in_sparse_q;
  logic                  out_sparse_q;

  logic [POS_BITS-1:0]   row_count_q, row_count_d;
  logic [ORDER_BITS-1:0] col_count_q, col_count_d;
  logic [PIDX_BITS-1:0]  col_base_q, col_base_d;

  logic signed [VALUE_BITS-1:0] value_q, value_d;
  logic [PIDX_BITS-1:0]         pidx_q, pidx_d;
  logic                         last_q, last_d;
  logic [POS_BITS-1:0]          i_q, i_d;
  logic [POS_BITS-1:0]          j_q, j_d;
  logic                         err_q, err_d;

  logic [POS_BITS-1:0]          row_q, row_d;
  logic [POS_BITS-1:0]          col_q, col_d;
  logic signed [VALUE_BITS-1:0] entry_q, entry_d;
  logic                         ev_q, ev_d;
  logic                         ie_q, ie_d;
  logic                         lo_q, lo_d;
  logic                         second_q, second_d;

  logic [ORDER_BITS-1:0]        n;
  logic [PIDX_BITS-1:0]         walk_i;
  logic                         walk_step;
  logic                         diag;
  op_e                          op;
  logic signed [VALUE_BITS-1:0] unit_result;

  // Effective order clamped to 1..MAX_ORDER.
  always_comb begin
    if (order_q == '0) begin
      n = ORDER_BITS'(1);
    end else if (order_q > ORDER_BITS'(MAX_ORDER)) begin
      n = ORDER_BITS'(MAX_ORDER);
    end else begin
      n = order_q;
    end
  end

  assign walk_i    = pidx_q - col_base_q;
  assign walk_step = (col_count_q < n) && (walk_i > PIDX_BITS'(col_count_q));
  assign diag      = (i_q == j_q);
  assign op        = diag ? OP_HALVE : OP_SCALE;

  pts_scale u_scale (
    .value_i  (value_q),
    .scale_i  (scale_q),
    .op_i     (op),
    .result_o (unit_result)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign row_o         = row_q;
  assign col_o         = col_q;
  assign entry_o       = entry_q;
  assign entry_valid_o = ev_q;
  assign index_error_o = ie_q;
  assign last_out_o    = lo_q;

  always_comb begin
    state_d     = state_q;
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    col_base_d  = col_base_q;
    value_d     = value_q;
    pidx_d      = pidx_q;
    last_d      = last_q;
    i_d         = i_q;
    j_d         = j_q;
    err_d       = err_q;
    row_d       = row_q;
    col_d       = col_q;
    entry_d     = entry_q;
    ev_d        = ev_q;
    ie_d        = ie_q;
    lo_d        = lo_q;
    second_d    = second_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d = value_i;
          pidx_d  = packed_index_i;
          last_d  = last_i;
          err_d   = 1'b0;
          if (in_sparse_q) begin
            if (packed_index_i < col_base_q) begin
              // A descending index leaves the walk state untouched.
              err_d   = 1'b1;
              state_d = S_CALC;
            end else begin
              state_d = S_WALK;
            end
          end else begin
            state_d = S_CALC;
            if (col_count_q >= n) begin
              err_d = 1'b1;
            end else begin
              i_d = row_count_q;
              j_d = POS_BITS'(col_count_q);
              if (ORDER_BITS'(row_count_q) < col_count_q) begin
                row_count_d = row_count_q + 1'b1;
              end else begin
                row_count_d = '0;
                col_count_d = col_count_q + 1'b1;
              end
            end
          end
        end
      end
      S_WALK: begin
        if (walk_step) begin
          col_base_d  = col_base_q + PIDX_BITS'(col_count_q) + 1'b1;
          col_count_d = col_count_q + 1'b1;
        end else begin
          i_d     = POS_BITS'(walk_i);
          j_d     = POS_BITS'(col_count_q);
          err_d   = (col_count_q >= n);
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        second_d = 1'b0;
        state_d  = S_OUT;
        if (err_q) begin
          row_d   = '0;
          col_d   = '0;
          entry_d = '0;
          ev_d    = 1'b0;
          ie_d    = 1'b1;
          lo_d    = last_q;
        end else if (out_sparse_q) begin
          if (!in_sparse_q && (value_q == '0)) begin
            // A dropped zero only leaves a marker when it closes the vector.
            row_d   = '0;
            col_d   = '0;
            entry_d = '0;
            ev_d    = 1'b0;
            ie_d    = 1'b0;
            lo_d    = 1'b1;
            if (!last_q) begin
              state_d = S_DONE;
            end
          end else begin
            row_d   = i_q;
            col_d   = j_q;
            entry_d = unit_result;
            ev_d    = 1'b1;
            ie_d    = 1'b0;
            lo_d    = last_q;
          end
        end else begin
          row_d = i_q;
          col_d = j_q;
          ev_d  = 1'b1;
          ie_d  = 1'b0;
          if (diag) begin
            entry_d = value_q;
            lo_d    = last_q;
          end else begin
            entry_d  = unit_result;
            lo_d     = 1'b0;
            second_d = 1'b1;
          end
        end
        if (last_q) begin
          row_count_d = '0;
          col_count_d = '0;
          col_base_d  = '0;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (second_q) begin
            // Mirrored entry of an off-diagonal element.
            row_d    = col_q;
            col_d    = row_q;
            lo_d     = last_q;
            second_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      order_q      <= ORDER_RESET;
      scale_q      <= SCALE_RESET;
      in_sparse_q  <= 1'b0;
      out_sparse_q <= 1'b0;
      row_count_q  <= '0;
      col_count_q  <= '0;
      col_base_q   <= '0;
      second_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      col_base_q  <= col_base_d;
      second_q    <= second_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ORDER:         order_q      <= cfg_wdata_i[ORDER_BITS-1:0];
          REG_OFFDIAG_SCALE: scale_q      <= cfg_wdata_i[SCALE_BITS-1:0];
          REG_INPUT_SPARSE:  in_sparse_q  <= cfg_wdata_i[0];
          REG_OUTPUT_SPARSE: out_sparse_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pidx_q  <= pidx_d;
    last_q  <= last_d;
    i_q     <= i_d;
    j_q     <= j_d;
    err_q   <= err_d;
    row_q   <= row_d;
    col_q   <= col_d;
    entry_q <= entry_d;
    ev_q    <= ev_d;
    ie_q    <= ie_d;
    lo_q    <= lo_d;
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the packed triangle to symmetric matrix unpacker.
module tb_top
  import pts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 100;
  localparam int TAIL_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1150;

  typedef struct {
    bit                            is_cfg;
    logic [CFG_IDX_BITS-1:0]       reg_idx;
    logic [CFG_DATA_BITS-1:0]      reg_data;
    logic signed [VALUE_BITS-1:0]  value;
    logic [PIDX_BITS-1:0]          pidx;
    logic                          last;
  } stim_t;

  typedef struct packed {
    logic [POS_BITS-1:0]           row;
    logic [POS_BITS-1:0]           col;
    logic signed [VALUE_BITS-1:0]  entry;
    logic                          entry_valid;
    logic                          index_error;
    logic                          last_out;
  } entry_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]       cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic signed [VALUE_BITS-1:0]   value_i = '0;
  logic [PIDX_BITS-1:0]           packed_index_i = '0;
  logic                           last_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [POS_BITS-1:0]            row_o;
  logic [POS_BITS-1:0]            col_o;
  logic signed [VALUE_BITS-1:0]   entry_o;
  logic                           entry_valid_o;
  logic                           index_error_o;
  logic                           last_out_o;

  packed_triangle_to_symmetric i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queues shared by the stimulus, the driver and the monitor.
  stim_t  pending_items[$];
  entry_t entries_due[$];
  int     mismatches = 0;
  int     results_seen = 0;

  // Predictor copy of the registers and the position counters.
  logic [ORDER_BITS-1:0]  ord_reg = ORDER_RESET;
  logic [SCALE_BITS-1:0]  scale_reg = SCALE_RESET;
  logic                   in_sparse_reg = 1'b0;
  logic                   out_sparse_reg = 1'b0;
  int                     row_cnt = 0;
  int                     col_cnt = 0;
  int                     col_base = 0;

  function automatic int clamp_order(int n);
    if (n < 1) return 1;
    if (n > MAX_ORDER) return MAX_ORDER;
    return n;
  endfunction

  // Exact product with the Q1.16 factor, floored and saturated.
  function automatic logic signed [VALUE_BITS-1:0] scale_offdiag(
      logic signed [VALUE_BITS-1:0] v);
    longint signed prod;
    longint signed lim;
    lim  = longint'(1) << (VALUE_BITS - 1);
    prod = (longint'(v) * longint'(scale_reg)) >>> SCALE_FRAC;
    if (prod >= lim) prod = lim - 1;
    else if (prod < -lim) prod = -lim;
    return prod[VALUE_BITS-1:0];
  endfunction

  task automatic set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_ORDER:         ord_reg = d[ORDER_BITS-1:0];
      REG_OFFDIAG_SCALE: scale_reg = d[SCALE_BITS-1:0];
      REG_INPUT_SPARSE:  in_sparse_reg = d[0];
      REG_OUTPUT_SPARSE: out_sparse_reg = d[0];
      default: ;
    endcase
  endtask

  task automatic expect_entry(int r, int c, logic signed [VALUE_BITS-1:0] e,
                              bit ev, bit er, bit ls);
    entry_t x;
    x.row = r[POS_BITS-1:0];
    x.col = c[POS_BITS-1:0];
    x.entry = e;
    x.entry_valid = ev;
    x.index_error = er;
    x.last_out = ls;
    entries_due.push_back(x);
  endtask

  // Works out the entries that one accepted element produces.
  task automatic unpack_element(stim_t it);
    int n, i, j, base;
    bit err;
    logic signed [VALUE_BITS-1:0] e;
    n = clamp_order(int'(ord_reg));
    i = 0;
    j = 0;
    err = 0;
    if (in_sparse_reg) begin
      if (int'(it.pidx) < col_base) begin
        err = 1;
      end else begin
        // Walk forward column by column until the index fits the column.
        base = col_base;
        j = col_cnt;
        i = int'(it.pidx) - base;
        while (j < n && i > j) begin
          base += j + 1;
          j++;
          i = int'(it.pidx) - base;
        end
        col_cnt = j;
        col_base = base;
        if (j >= n) err = 1;
      end
    end else begin
      if (col_cnt >= n) begin
        err = 1;
      end else begin
        i = row_cnt;
        j = col_cnt;
        if (row_cnt < col_cnt) begin
          row_cnt++;
        end else begin
          row_cnt = 0;
          col_cnt++;
        end
      end
    end

    if (err) begin
      expect_entry(0, 0, '0, 0, 1, it.last);
    end else if (out_sparse_reg) begin
      if (!in_sparse_reg && it.value == 0) begin
        if (it.last) expect_entry(0, 0, '0, 0, 0, 1);
      end else begin
        e = (i < j) ? scale_offdiag(it.value) : (it.value >>> 1);
        expect_entry(i, j, e, 1, 0, it.last);
      end
    end else if (i < j) begin
      e = scale_offdiag(it.value);
      expect_entry(i, j, e, 1, 0, 0);
      expect_entry(j, i, e, 1, 0, it.last);
    end else begin
      expect_entry(i, j, it.value, 1, 0, it.last);
    end

    if (it.last) begin
      row_cnt = 0;
      col_cnt = 0;
      col_base = 0;
    end
  endtask

  // Stimulus construction. The generator tracks order and input mode so that
  // it can build well-formed vectors.
  int data_items = 0;
  int gen_n = 1;
  bit gen_in_sparse = 0;

  task automatic add_reg_write(logic [CFG_IDX_BITS-1:0] idx, int d);
    stim_t s;
    s = '{default: '0};
    s.is_cfg = 1;
    s.reg_idx = idx;
    s.reg_data = d[CFG_DATA_BITS-1:0];
    pending_items.push_back(s);
    if (idx == REG_ORDER) gen_n = clamp_order(d & 127);
    if (idx == REG_INPUT_SPARSE) gen_in_sparse = d[0];
  endtask

  task automatic add_element(logic signed [VALUE_BITS-1:0] v, logic [PIDX_BITS-1:0] p,
                             logic ls);
    stim_t s;
    s = '{default: '0};
    s.value = v;
    s.pidx = p;
    s.last = ls;
    pending_items.push_back(s);
    data_items++;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_dense_vector(int n, bit noisy);
    int total, len, extra;
    total = n * (n + 1) / 2;
    len = total;
    extra = 0;
    // Large orders are cut short by an early last to keep the run brief.
    if (len > 45) len = $urandom_range(1, 45);
    if (noisy) begin
      if ($urandom_range(0, 1) == 1 && len == total) extra = $urandom_range(1, 3);
      else len = $urandom_range(1, len);
    end
    for (int q = 0; q < len + extra; q++)
      add_element(rand_value(), PIDX_BITS'($urandom), q == len + extra - 1);
  endtask

  task automatic add_sparse_vector(int n, bit noisy);
    int total, k, cur, idx;
    total = n * (n + 1) / 2;
    k = $urandom_range(1, 10);
    cur = $urandom_range(0, (total - 1) / k);
    for (int q = 0; q < k; q++) begin
      idx = cur;
      if (noisy && $urandom_range(0, 3) == 0)
        idx = ($urandom_range(0, 1) == 1) ? $urandom_range(total, 4095)
                                          : $urandom_range(0, cur);
      add_element(rand_value(), PIDX_BITS'(idx), q == k - 1);
      cur += $urandom_range(0, 2 * total / k);
      if (cur > total - 1) cur = total - 1;
    end
  endtask

  initial begin
    int r, ord, scl;
    bit noisy;

    // Reset settings: a single diagonal element, then one past the triangle.
    add_element(32'sh0005_0000, '0, 1'b0);
    add_element(-32'sd7, '0, 1'b1);

    // Order 3 with the largest factor: negative saturation and a floored product.
    add_reg_write(REG_ORDER, 3);
    add_reg_write(REG_OFFDIAG_SCALE, 131071);
    add_element(32'h7FFF_FFFF, '0, 1'b0);
    add_element(32'h8000_0000, '0, 1'b0);
    add_element(32'h7FFF_FFFF, '0, 1'b0);
    add_element(-32'sd1, '0, 1'b0);
    add_element(32'sd12345, 12'hFFF, 1'b0);
    add_element('0, '0, 1'b1);

    // Upper entries only, zero factor: dropped zeros and a halved diagonal.
    add_reg_write(REG_OUTPUT_SPARSE, 1);
    add_reg_write(REG_OFFDIAG_SCALE, 0);
    add_element('0, '0, 1'b0);
    add_element(-32'sd1, '0, 1'b0);
    add_element(-32'sd1, '0, 1'b0);
    add_element(32'h8000_0000, '0, 1'b0);
    add_element('0, '0, 1'b0);
    add_element(32'h8000_0000, '0, 1'b1);
    // Order zero acts as one; a zero carrying last leaves only a marker.
    add_reg_write(REG_ORDER, 0);
    add_element('0, '0, 1'b1);

    // Packed indices at full order, then a descending and an oversized index.
    add_reg_write(REG_ORDER, 64);
    add_reg_write(REG_OFFDIAG_SCALE, 65536);
    add_reg_write(REG_INPUT_SPARSE, 1);
    add_reg_write(REG_OUTPUT_SPARSE, 0);
    add_element(32'sh0001_0000, 12'd0, 1'b0);
    add_element(-32'sh0002_0000, 12'd5, 1'b0);
    add_element(32'sh7654_3210, 12'd2079, 1'b1);
    add_element(-32'sh0003_8000, 12'd10, 1'b0);
    add_element(32'sd99, 12'd4, 1'b0);
    add_element(32'sd42, 12'hFFF, 1'b1);

    // Mode change in the middle of a vector with an oversized order.
    add_reg_write(REG_ORDER, 127);
    add_reg_write(REG_INPUT_SPARSE, 0);
    add_element(32'sd11, '0, 1'b0);
    add_element(32'sd22, '0, 1'b0);
    add_element(32'sd33, '0, 1'b0);
    add_reg_write(REG_INPUT_SPARSE, 1);
    add_reg_write(REG_OUTPUT_SPARSE, 1);
    add_element(32'sd44, 12'd7, 1'b0);
    add_element(32'sd55, 12'd9, 1'b1);

    r = data_items;
    while (data_items < r + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       ord = 0;
        1:       ord = 64;
        2:       ord = $urandom_range(65, 127);
        3:       ord = $urandom_range(9, 63);
        default: ord = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       scl = 0;
        1:       scl = 131071;
        2:       scl = 65536;
        default: scl = $urandom_range(0, 131071);
      endcase
      add_reg_write(REG_ORDER, ord);
      add_reg_write(REG_OFFDIAG_SCALE, scl);
      add_reg_write(REG_INPUT_SPARSE, $urandom_range(0, 1));
      add_reg_write(REG_OUTPUT_SPARSE, $urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) begin
        noisy = ($urandom_range(0, 4) == 0);
        if (gen_in_sparse) add_sparse_vector(gen_n, noisy);
        else add_dense_vector(gen_n, noisy);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mode 0 never idles, mode 1 draws a random wait for every item, mode 2 idles now and then.
  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 13);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  // Sender: offers elements and performs register writes once the block is idle.
  stim_t cur_item;
  int    items_taken = 0;
  int    tx_gap = 0;
  int    tx_mode = 1;
  int    settle = 0;

  always @(posedge clk_i) begin : driver
    stim_t nx;
    logic  v_next;
    logic  we_next;
    if (rst_ni) begin
      v_next = in_valid_i;
      we_next = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        unpack_element(cur_item);
        items_taken++;
        if (items_taken % 40 == 0) tx_mode = $urandom_range(0, 2);
        tx_gap = draw_wait(tx_mode);
        v_next = 1'b0;
        settle = 0;
      end
      if (entries_due.size() != 0) settle = 0;
      else if (settle < SETTLE_CYCLES) settle++;
      if (!v_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() != 0) begin
          nx = pending_items[0];
          if (!nx.is_cfg) begin
            pending_items.delete(0);
            cur_item = nx;
            v_next = 1'b1;
            value_i <= nx.value;
            packed_index_i <= nx.pidx;
            last_i <= nx.last;
          end else if (settle >= SETTLE_CYCLES) begin
            pending_items.delete(0);
            set_register(nx.reg_idx, nx.reg_data);
            we_next = 1'b1;
            cfg_index_i <= nx.reg_idx;
            cfg_wdata_i <= nx.reg_data;
          end
        end
      end
      in_valid_i <= v_next;
      cfg_we_i <= we_next;
    end
  end

  // Long receiver hold-off once, so that the block backs up its input.
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks every taken entry against the oldest expectation.
  int rx_wait = 0;
  int rx_mode = 1;

  task automatic note_fault(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : monitor
    entry_t got;
    entry_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {row_o, col_o, entry_o, entry_valid_o, index_error_o, last_out_o};
        if (entries_due.size() == 0) begin
          note_fault($sformatf({"unexpected entry: row %0d col %0d entry %0d ",
                                "valid %0b err %0b last %0b"},
                               got.row, got.col, got.entry, got.entry_valid,
                               got.index_error, got.last_out));
        end else begin
          want = entries_due.pop_front();
          if (got !== want)
            note_fault($sformatf({"entry mismatch: expected row %0d col %0d entry %0d ",
                                  "valid %0b err %0b last %0b, got row %0d col %0d ",
                                  "entry %0d valid %0b err %0b last %0b"},
                                 want.row, want.col, want.entry, want.entry_valid,
                                 want.index_error, want.last_out,
                                 got.row, got.col, got.entry, got.entry_valid,
                                 got.index_error, got.last_out));
        end
        results_seen++;
        if (results_seen % 50 == 0) rx_mode = $urandom_range(0, 2);
        rx_wait = draw_wait(rx_mode);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (hold_left != 0) || (rx_wait != 0);
    end
  end

  // End of run and watchdog.
  int cycles = 0;
  int tail = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (pending_items.size() == 0 && !in_valid_i && entries_due.size() == 0) begin
      tail++;
      if (tail > TAIL_CYCLES) begin
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
      end
    end else begin
      tail = 0;
    end
  end

endmodule
